FILE: rtl/flc_pkg.sv
// Shared types and constants for the flash record checker.
// No dependencies; the CRC, parser and top-level files refer to this package by scoped name.
package flc_pkg;

  localparam logic [31:0] REC_MAGIC = 32'h464C_4D31;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam int unsigned HDR_BYTES = 10;

  // Byte offsets inside the record header, and of the first payload byte
  localparam logic [11:0] POS_MAGIC_LAST = 12'd3;
  localparam logic [11:0] POS_LEN_FIRST  = 12'd4;
  localparam logic [11:0] POS_LEN_LAST   = 12'd5;
  localparam logic [11:0] POS_CRC_FIRST  = 12'd6;
  localparam logic [11:0] POS_PAYLOAD    = 12'd10;

  typedef enum logic [1:0] {
    VERDICT_OK           = 2'd0,
    VERDICT_BAD_MAGIC    = 2'd1,
    VERDICT_BAD_LENGTH   = 2'd2,
    VERDICT_CRC_MISMATCH = 2'd3
  } verdict_t;

  typedef struct packed {
    logic       page_start;
    logic [7:0] page_byte;
  } byte_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [10:0] payload_length;
  } result_t;

endpackage

FILE: rtl/flc_if.sv
// Handshake channels of the flash record checker: page bytes in, verdicts out.
// No dependencies.
interface flc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] page_byte;
  logic       page_start;

  modport source (output valid, output page_byte, output page_start, input ready);
  modport sink   (input valid, input page_byte, input page_start, output ready);
endinterface

interface flc_verdict_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [10:0] payload_length;

  modport source (output valid, output verdict, output payload_length, input ready);
  modport sink   (input valid, input verdict, input payload_length, output ready);
endinterface

FILE: rtl/flc_crc_byte.sv
// One byte of reflected CRC-32, fully unrolled (eight shift/xor steps).
// Depends on flc_pkg for the polynomial.
module flc_crc_byte (
  input  logic [31:0] crc,
  input  logic [7:0]  data,
  output logic [31:0] crc_next
);

  always_comb begin
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ flc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_next = c;
  end

endmodule

FILE: rtl/flc_record_fsm.sv
// Record parser: header assembly, magic/length checks and running CRC.
// Depends on flc_pkg and flc_crc_byte.
module flc_record_fsm #(
  parameter int unsigned PAGE_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  flc_pkg::byte_item_t item,
  output logic                fire,
  output flc_pkg::result_t    result
);

  localparam logic [15:0] MaxLen = 16'(PAGE_BYTES - flc_pkg::HDR_BYTES);

  logic [11:0] byte_position, byte_position_next;
  logic [31:0] magic_word, magic_word_next;
  logic [15:0] length_field, length_field_next;
  logic [31:0] stored_checksum, stored_checksum_next;
  logic [31:0] running_checksum, running_checksum_next;
  logic        verdict_given, verdict_given_next;

  // state as seen by this byte, after a possible page restart
  logic [11:0] cur_pos;
  logic [31:0] cur_magic;
  logic [15:0] cur_len;
  logic [31:0] cur_stored;
  logic [31:0] cur_crc;
  logic        cur_given;
  logic [31:0] crc_upd;
  logic [11:0] crc_off;
  logic [15:0] payload_idx;

  assign cur_pos    = item.page_start ? '0 : byte_position;
  assign cur_magic  = item.page_start ? '0 : magic_word;
  assign cur_len    = item.page_start ? '0 : length_field;
  assign cur_stored = item.page_start ? '0 : stored_checksum;
  assign cur_crc    = item.page_start ? flc_pkg::ALL_ONES : running_checksum;
  assign cur_given  = item.page_start ? 1'b0 : verdict_given;
  assign crc_off     = cur_pos - flc_pkg::POS_CRC_FIRST;
  assign payload_idx = {4'd0, cur_pos} - 16'd9;

  flc_crc_byte u_crc (
    .crc      (cur_crc),
    .data     (item.page_byte),
    .crc_next (crc_upd)
  );

  always_comb begin
    byte_position_next    = byte_position;
    magic_word_next       = magic_word;
    length_field_next     = length_field;
    stored_checksum_next  = stored_checksum;
    running_checksum_next = running_checksum;
    verdict_given_next    = verdict_given;
    fire                  = 1'b0;
    result.verdict        = flc_pkg::VERDICT_OK;
    result.payload_length = '0;
    if (step) begin
      byte_position_next    = cur_pos;
      magic_word_next       = cur_magic;
      length_field_next     = cur_len;
      stored_checksum_next  = cur_stored;
      running_checksum_next = cur_crc;
      verdict_given_next    = cur_given;
      if (!cur_given) begin
        byte_position_next = cur_pos + 12'd1;
        if (cur_pos < flc_pkg::POS_LEN_FIRST) begin
          magic_word_next = cur_magic | (32'(item.page_byte) << {cur_pos[1:0], 3'b000});
          if (cur_pos == flc_pkg::POS_MAGIC_LAST && magic_word_next != flc_pkg::REC_MAGIC) begin
            fire               = 1'b1;
            verdict_given_next = 1'b1;
            result.verdict     = flc_pkg::VERDICT_BAD_MAGIC;
          end
        end else if (cur_pos < flc_pkg::POS_CRC_FIRST) begin
          length_field_next = cur_len | (16'(item.page_byte) << {cur_pos[0], 3'b000});
          if (cur_pos == flc_pkg::POS_LEN_LAST &&
              (length_field_next == 16'd0 || length_field_next > MaxLen)) begin
            fire               = 1'b1;
            verdict_given_next = 1'b1;
            result.verdict     = flc_pkg::VERDICT_BAD_LENGTH;
          end
        end else if (cur_pos < flc_pkg::POS_PAYLOAD) begin
          stored_checksum_next = cur_stored | (32'(item.page_byte) << {crc_off[1:0], 3'b000});
        end else begin
          running_checksum_next = crc_upd;
          if (payload_idx >= cur_len) begin
            fire               = 1'b1;
            verdict_given_next = 1'b1;
            if (~crc_upd == cur_stored) begin
              result.verdict        = flc_pkg::VERDICT_OK;
              result.payload_length = cur_len[10:0];
            end else begin
              result.verdict = flc_pkg::VERDICT_CRC_MISMATCH;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      magic_word       <= '0;
      length_field     <= '0;
      stored_checksum  <= '0;
      running_checksum <= flc_pkg::ALL_ONES;
      verdict_given    <= 1'b1;
    end else begin
      byte_position    <= byte_position_next;
      magic_word       <= magic_word_next;
      length_field     <= length_field_next;
      stored_checksum  <= stored_checksum_next;
      running_checksum <= running_checksum_next;
      verdict_given    <= verdict_given_next;
    end
  end

  // one verdict per record: after reporting, the parser idles
  a_fire_idles: assert property (@(posedge clk) disable iff (rst) fire |=> verdict_given)
    else $error("parser not idle after verdict");
  a_reset_idle: assert property (@(posedge clk) rst |=> verdict_given)
    else $error("parser active after reset");

endmodule

FILE: rtl/flash_record_checker.sv
// Flash record checker. Takes a page one byte per item on `page`, with page_start on byte 0,
// and gives one verdict per record on `result`: bad magic after byte 3, bad length after
// byte 5, or the CRC-32 outcome after the last payload byte (byte 9 + length). Bytes before
// the first page start and after a verdict are dropped; a page start restarts parsing. One
// byte is taken every cycle while no verdict waits unread on `result`: the input register,
// the header/CRC update and the result register form a two-stage pipeline, and a verdict
// leaves from the result register once its last byte has passed the input register.
// Depends on flc_pkg, flc_if and flc_record_fsm.
module flash_record_checker #(
  parameter int unsigned PAGE_BYTES = 2048
) (
  input logic           clk,
  input logic           rst,
  flc_byte_if.sink      page,
  flc_verdict_if.source result
);

  // input register
  logic                s1_valid;
  flc_pkg::byte_item_t s1_item;

  // result register
  logic                res_valid;
  flc_pkg::result_t    res_data;

  logic                out_free;
  logic                advance;
  logic                fire;
  flc_pkg::result_t    step_result;

  // the result register is free when empty or being read this cycle
  assign out_free   = !res_valid || result.ready;
  assign advance    = s1_valid && out_free;
  assign page.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (page.ready) begin
      s1_valid <= page.valid;
    end
    if (page.ready && page.valid) begin
      s1_item.page_byte  <= page.page_byte;
      s1_item.page_start <= page.page_start;
    end
  end

  flc_record_fsm #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (s1_item),
    .fire   (fire),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= advance && fire;
    end
    if (advance && fire) begin
      res_data <= step_result;
    end
  end

  assign result.valid          = res_valid;
  assign result.verdict        = res_data.verdict;
  assign result.payload_length = res_data.payload_length;

  // a failed record never carries a length
  a_len_only_ok: assert property (@(posedge clk) disable iff (rst)
      res_valid && res_data.verdict != flc_pkg::VERDICT_OK |-> res_data.payload_length == '0)
    else $error("length reported with failing verdict");
  // a byte held in the input register stays put while the result side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
      s1_valid && !out_free |=> s1_valid && $stable(s1_item))
    else $error("input register changed while stalled");
  // the parser only steps on a held byte
  a_step_valid: assert property (@(posedge clk) disable iff (rst)
      fire |-> advance)
    else $error("verdict without a byte");

endmodule
